// ===== design/assert_macros.svh =====
// assertion macros shared by the qualifier rtl
// no dependencies; compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// checked on every clock edge outside reset
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== design/wtcq_pkg.sv =====
// types and constants of the windowed trend cooling qualifier
// no dependencies; used by the top level
package wtcq_pkg;

	localparam int WINDOW_DEPTH = 60;
	localparam int TREND_DEPTH  = 12;
	localparam int TREND_USED   = (TREND_DEPTH > WINDOW_DEPTH) ? WINDOW_DEPTH : TREND_DEPTH;
	localparam int TREND_START  = WINDOW_DEPTH - TREND_USED;

	localparam int TEMP_W   = 12;
	localparam int MARGIN_W = 11;
	localparam int PTR_W    = $clog2(WINDOW_DEPTH);
	localparam int CNT_W    = $clog2(WINDOW_DEPTH + 1);
	localparam int COEF_W   = $clog2(TREND_USED) + 1;
	localparam int PROD_W   = COEF_W + TEMP_W;
	localparam int ACC_W    = TEMP_W + $clog2(TREND_USED * TREND_USED) + 1;

	localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(160);

	typedef enum logic [0:0] {
		REG_MAX_TEMPERATURE  = 1'b0,
		REG_DOOR_OPEN_MARGIN = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] sample_temperature;
		logic                     sample_valid;
	} smp_t;

	typedef struct packed {
		logic cooling_demand;
		logic window_full;
	} res_t;

endpackage

// ===== design/wtcq_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
module wtcq_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 60
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/windowed_trend_cooling_qualifier_unit.sv =====
// windowed trend cooling qualifier, top level
// depends on wtcq_pkg, wtcq_ram and assert_macros.svh
// flow: an invalid request or one taken while the window fills goes from acceptance
//   through the finish step to the result register; with a full window it first walks and drains
// a new request is taken only back in idle, after the finish step; with a full window this waits on
//   the walk of the single ram read port over all WINDOW_DEPTH stored samples
// reset: arst_n clears control, limit to 0, margin to 160, demand to 0; store left as is
`include "assert_macros.svh"

module windowed_trend_cooling_qualifier_unit (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// configuration write channel
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  wtcq_pkg::cfg_reg_t                      cfg_index,
	input  logic [wtcq_pkg::TEMP_W-1:0]             cfg_data,
	// sample request channel
	input  logic                                    smp_valid,
	output logic                                    smp_ready,
	input  wtcq_pkg::smp_t                          smp,
	// result channel
	output logic                                    res_valid,
	input  logic                                    res_ready,
	output wtcq_pkg::res_t                          res
);

	import wtcq_pkg::*;

	// control
	state_t                    state_q, state_d;
	logic [PTR_W-1:0]          wp_q;        // next slot to write
	logic [CNT_W-1:0]          cnt_q;       // samples held, saturating
	logic                      demand_q;

	// configuration
	logic signed [TEMP_W-1:0]  lim_q;
	logic [MARGIN_W-1:0]       margin_q;

	// request being worked on
	logic signed [TEMP_W-1:0]  t_q;
	logic                      sval_q;

	// walk sequencer: issue side
	logic [PTR_W-1:0]          k_q;
	logic [PTR_W-1:0]          rd_ptr_q;

	// walk sequencer: data side, in the cycle after the ram read
	logic                      vld_s1;
	logic [PTR_W-1:0]          k_s1;
	logic [TEMP_W-1:0]         rd_data;
	logic                      above_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [COEF_W-1:0]  coef_q;

	// result register
	logic                      res_valid_q;
	res_t                      res_q;

	logic                      accept;
	logic                      store_we;
	logic                      walk_re;
	logic                      fin_fire;
	logic                      full_now;
	logic                      full_after;
	logic [PTR_W-1:0]          wp_inc;
	logic [PTR_W-1:0]          rd_ptr_inc;
	logic signed [TEMP_W-1:0]  rd_temp;
	logic signed [PROD_W-1:0]  prod;
	logic signed [TEMP_W:0]    door_bound;
	logic signed [TEMP_W:0]    t_ext;
	logic                      demand_d;

	assign cfg_ready = 1'b1;
	assign smp_ready = (state_q == ST_IDLE);
	assign accept    = smp_valid && smp_ready;
	assign store_we  = accept && smp.sample_valid;
	assign walk_re   = (state_q == ST_WALK);
	assign fin_fire  = (state_q == ST_FINISH) && (!res_valid_q || res_ready);

	assign full_now   = (cnt_q == CNT_W'(WINDOW_DEPTH));
	// window is full once this request's sample is stored
	assign full_after = (cnt_q >= CNT_W'(WINDOW_DEPTH - 1));

	assign wp_inc     = (wp_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
	assign rd_ptr_inc = (rd_ptr_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);

	// sample store, written on acceptance of a valid sample, walked oldest first afterwards
	wtcq_ram #(
		.WIDTH(TEMP_W),
		.DEPTH(WINDOW_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (wp_q),
		.wdata (smp.sample_temperature),
		.re    (walk_re),
		.raddr (rd_ptr_q),
		.rdata (rd_data)
	);

	// shared unit: one compare against the limit and one trend multiply-accumulate
	assign rd_temp = signed'(rd_data);
	assign prod    = PROD_W'(coef_q) * PROD_W'(rd_temp);

	// demand decision at the end of the request
	assign t_ext      = {t_q[TEMP_W-1], t_q};
	assign door_bound = {lim_q[TEMP_W-1], lim_q} + signed'({2'b00, margin_q});

	always_comb begin
		demand_d = demand_q;
		if (sval_q && full_now) begin
			priority if (t_q <= lim_q) begin
				demand_d = 1'b0;
			end else if (t_ext > door_bound) begin
				// far above the limit: door open
				demand_d = 1'b0;
			end else if (!demand_q && above_q && (acc_q > ACC_W'(0))) begin
				demand_d = 1'b1;
			end else begin
				demand_d = demand_q;
			end
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (smp_valid) begin
					state_d = (smp.sample_valid && full_after) ? ST_WALK : ST_FINISH;
				end
			end
			ST_WALK: begin
				if (k_q == PTR_W'(WINDOW_DEPTH - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!res_valid_q || res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q    <= '0;
			margin_q <= MARGIN_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MAX_TEMPERATURE:  lim_q    <= signed'(cfg_data);
				REG_DOOR_OPEN_MARGIN: margin_q <= cfg_data[MARGIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// window bookkeeping and demand flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			cnt_q    <= '0;
			demand_q <= 1'b0;
		end else begin
			if (store_we) begin
				wp_q <= wp_inc;
				if (!full_now) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (fin_fire) begin
				demand_q <= demand_d;
			end
		end
	end

	// walk issue side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= '0;
			rd_ptr_q <= '0;
			vld_s1   <= 1'b0;
			k_s1     <= '0;
		end else begin
			vld_s1 <= walk_re;
			k_s1   <= k_q;
			if (accept) begin
				k_q      <= '0;
				// oldest sample sits just past the slot written now
				rd_ptr_q <= wp_inc;
			end else if (walk_re) begin
				k_q      <= k_q + PTR_W'(1);
				rd_ptr_q <= rd_ptr_inc;
			end
		end
	end

	// walk data side: all-above check and trend sum over the newest entries
	always_ff @(posedge clk) begin
		if (accept) begin
			t_q     <= smp.sample_temperature;
			sval_q  <= smp.sample_valid;
			above_q <= 1'b1;
			acc_q   <= '0;
			coef_q  <= COEF_W'(1 - TREND_USED);
		end else if (vld_s1) begin
			above_q <= above_q && (rd_temp > lim_q);
			if (k_s1 >= PTR_W'(TREND_START)) begin
				acc_q  <= acc_q + ACC_W'(prod);
				coef_q <= coef_q + COEF_W'(2);
			end
		end
	end

	// result register, frees the sequencer while the result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fin_fire) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			res_q.cooling_demand <= demand_d;
			res_q.window_full    <= full_now;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// fill count never passes the window depth
	`ASSERT_CLKD(a_cnt_bound, clk, arst_n, cnt_q <= CNT_W'(WINDOW_DEPTH), "fill count beyond window")
	// the store is only walked once every slot has been written
	`ASSERT_CLKD(a_walk_full, clk, arst_n, (state_q == ST_WALK) |-> full_now, "walk on partial window")
	// a new result only comes out of the finishing step
	`ASSERT_CLKD(a_res_src, clk, arst_n, $rose(res_valid) |-> $past(state_q == ST_FINISH), "stray result")
	// demand only rises after a walk that saw every sample above the limit
	`ASSERT_CLKD(a_dem_rise, clk, arst_n, $rose(demand_q) |-> ($past(state_q == ST_FINISH) && above_q && full_now), "demand set without qualifying walk")

endmodule
